/* rtl/core/mns_pkg.sv */
// ----------------------------------------------------------------------------
// mns_pkg
// Shared constants, payload types and memory request type for the melody
// note sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mns_pkg;

  // note table
  localparam int MAX_NOTES = 64;
  localparam int NOTE_AW   = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int IDX_W     = $clog2(MAX_NOTES + 1);

  // tone generator clock and period divider
  localparam int TONE_CLOCK_HZ = 62500;
  localparam int DIV_W         = $clog2(TONE_CLOCK_HZ + 1);
  localparam int DIV_CNT_W     = $clog2(DIV_W + 1);

  // time base
  localparam int MS_W      = 10;
  localparam int MS_PER_S  = 1000;

  // volume
  localparam int VOL_W     = 7;
  localparam int VOL_MAX   = 75;
  localparam int VOL_STEP  = 5;

  // compare = top * volume / 100, done as a reciprocal multiply
  localparam int PROD_W       = 15;
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int SCALED_W     = 28;

  localparam logic [15:0] GAP_RESET = 16'd50;

  // command codes
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_LOAD     = 3'd1;
  localparam logic [2:0] MODE_PLAY     = 3'd2;
  localparam logic [2:0] MODE_VOL_UP   = 3'd3;
  localparam logic [2:0] MODE_VOL_DOWN = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  note_slot;
    logic [15:0] note_freq;
    logic [15:0] note_duration;
    logic [6:0]  song_length;
  } in_t;

  typedef struct packed {
    logic        tone_on;
    logic [7:0]  tone_top;
    logic [7:0]  tone_compare;
    logic [15:0] seconds;
    logic [6:0]  note_position;
    logic        in_gap;
    logic [6:0]  volume_level;
  } out_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] duration;
  } note_t;

  typedef struct packed {
    logic               we;
    logic [NOTE_AW-1:0] waddr;
    note_t              wdata;
    logic [NOTE_AW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

/* rtl/core/melody_note_sequencer.sv */
// ----------------------------------------------------------------------------
// melody_note_sequencer
// Plays a note table on a pwm tone generator, driven by 1 ms tick beats.
// ----------------------------------------------------------------------------
// flow: each beat passes exec and out; a note start adds a frequency check,
//   and a sounding note also the bit-serial period divider (one bit of tone
//   clock / freq per cycle) and the compare multiply
// handshake: one beat in flight; the next beat can be accepted in the cycle
//   after the result is registered
// reset: synchronous active low; clears time, play and volume, gap back to 50
`default_nettype none

module melody_note_sequencer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mns_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mns_pkg::out_t       out_data,
  input  wire logic           cfg_wr_en,
  input  wire logic [15:0]    cfg_wr_data
);
  import mns_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FCHK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state_r,     state_nxt;
  in_t               item_r,      item_nxt;
  logic [15:0]       gap_ms_r;
  logic [MS_W-1:0]   ms_r,        ms_nxt;
  logic [15:0]       sec_r,       sec_nxt;
  logic [15:0]       phase_r,     phase_nxt;
  logic [IDX_W-1:0]  play_idx_r,  play_idx_nxt;
  logic [IDX_W-1:0]  play_len_r,  play_len_nxt;
  logic              gap_flag_r,  gap_flag_nxt;
  logic [VOL_W-1:0]  volume_r,    volume_nxt;
  logic              tone_on_r,   tone_on_nxt;
  logic [7:0]        top_r,       top_nxt;
  logic [7:0]        cmp_r,       cmp_nxt;
  logic [PROD_W-1:0] prod_r,      prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r,       out_nxt;

  mem_req_t          mem_req;
  note_t             mem_rdata;
  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;

  logic [MS_W-1:0]   ms_inc;
  logic [15:0]       ph;
  logic              gp;
  logic [IDX_W-1:0]  idx;
  logic              start_note;
  logic [7:0]        ticks;
  logic [SCALED_W-1:0] scaled;

  mns_note_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  mns_tone_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (mem_rdata.freq),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    ms_nxt        = ms_r;
    sec_nxt       = sec_r;
    phase_nxt     = phase_r;
    play_idx_nxt  = play_idx_r;
    play_len_nxt  = play_len_r;
    gap_flag_nxt  = gap_flag_r;
    volume_nxt    = volume_r;
    tone_on_nxt   = tone_on_r;
    top_nxt       = top_r;
    cmp_nxt       = cmp_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    div_start     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = item_r.note_slot[NOTE_AW-1:0];
    mem_req.wdata = {item_r.note_freq, item_r.note_duration};
    mem_req.raddr = play_idx_r[NOTE_AW-1:0];
    ms_inc        = ms_r + 1'b1;
    ph            = phase_r + 16'd1;
    gp            = gap_flag_r;
    idx           = play_idx_r;
    start_note    = 1'b0;
    ticks         = div_q[7:0];
    scaled        = SCALED_W'(prod_r) * SCALED_W'(DIV100_MUL);

    unique case (state_r)
      S_IDLE: begin
        // read the duration of the current note while the beat lands
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_OUT;
        case (item_r.mode)
          MODE_TICK: begin
            if (32'(ms_inc) >= 32'(MS_PER_S)) begin
              ms_nxt  = '0;
              sec_nxt = sec_r + 16'd1;
            end else begin
              ms_nxt = ms_inc;
            end
            if (play_idx_r < play_len_r) begin
              if (!gp && ph == mem_rdata.duration) begin
                ph          = '0;
                gp          = 1'b1;
                tone_on_nxt = 1'b0;
                top_nxt     = '0;
                cmp_nxt     = '0;
              end
              // zero gap ends on the same tick as the note
              if (gp && ph == gap_ms_r) begin
                idx = play_idx_r + 1'b1;
                gp  = 1'b0;
                ph  = '0;
                if (idx < play_len_r) begin
                  start_note = 1'b1;
                end else begin
                  tone_on_nxt = 1'b0;
                  top_nxt     = '0;
                  cmp_nxt     = '0;
                end
              end
            end
            phase_nxt    = ph;
            gap_flag_nxt = gp;
            play_idx_nxt = idx;
          end
          MODE_LOAD: begin
            mem_req.we = (32'(item_r.note_slot) < 32'(MAX_NOTES));
          end
          MODE_PLAY: begin
            idx          = '0;
            play_len_nxt = (32'(item_r.song_length) > 32'(MAX_NOTES)) ?
                           IDX_W'(MAX_NOTES) : IDX_W'(item_r.song_length);
            play_idx_nxt = '0;
            gap_flag_nxt = 1'b0;
            phase_nxt    = '0;
            if (play_len_nxt != '0) begin
              start_note = 1'b1;
            end else begin
              tone_on_nxt = 1'b0;
              top_nxt     = '0;
              cmp_nxt     = '0;
            end
          end
          MODE_VOL_UP: begin
            if (32'(volume_r) < 32'(VOL_MAX)) begin
              volume_nxt = volume_r + VOL_W'(VOL_STEP);
            end
          end
          MODE_VOL_DOWN: begin
            if (volume_r != '0) begin
              volume_nxt = volume_r - VOL_W'(VOL_STEP);
            end
          end
          default: begin
          end
        endcase
        if (start_note) begin
          mem_req.raddr = idx[NOTE_AW-1:0];
          state_nxt     = S_FCHK;
        end
      end

      S_FCHK: begin
        if (mem_rdata.freq == '0) begin
          tone_on_nxt = 1'b0;
          top_nxt     = '0;
          cmp_nxt     = '0;
          state_nxt   = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          if (ticks == '0) begin
            tone_on_nxt = 1'b0;
            top_nxt     = '0;
            cmp_nxt     = '0;
            state_nxt   = S_OUT;
          end else begin
            top_nxt   = ticks - 8'd1;
            prod_nxt  = PROD_W'(top_nxt * PROD_W'(volume_r));
            state_nxt = S_MUL;
          end
        end
      end

      S_MUL: begin
        tone_on_nxt = 1'b1;
        cmp_nxt     = scaled[DIV100_SHIFT +: 8];
        state_nxt   = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.tone_on       = tone_on_r;
          out_nxt.tone_top      = top_r;
          out_nxt.tone_compare  = cmp_r;
          out_nxt.seconds       = sec_r;
          out_nxt.note_position = 7'(play_idx_r);
          out_nxt.in_gap        = gap_flag_r;
          out_nxt.volume_level  = volume_r;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gap_ms_r    <= GAP_RESET;
      ms_r        <= '0;
      sec_r       <= '0;
      phase_r     <= '0;
      play_idx_r  <= '0;
      play_len_r  <= '0;
      gap_flag_r  <= 1'b0;
      volume_r    <= '0;
      tone_on_r   <= 1'b0;
      top_r       <= '0;
      cmp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gap_ms_r    <= cfg_wr_en ? cfg_wr_data : gap_ms_r;
      ms_r        <= ms_nxt;
      sec_r       <= sec_nxt;
      phase_r     <= phase_nxt;
      play_idx_r  <= play_idx_nxt;
      play_len_r  <= play_len_nxt;
      gap_flag_r  <= gap_flag_nxt;
      volume_r    <= volume_nxt;
      tone_on_r   <= tone_on_nxt;
      top_r       <= top_nxt;
      cmp_r       <= cmp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_idx_in_song: assert property (@(posedge clk) disable iff (!rst_n)
    play_idx_r <= play_len_r)
    else $error("play index beyond song length");

  a_gap_silent: assert property (@(posedge clk) disable iff (!rst_n)
    gap_flag_r |-> (!tone_on_r && top_r == '0 && cmp_r == '0))
    else $error("tone running during gap");

  a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(volume_r) <= 32'(VOL_MAX))
    else $error("volume out of range");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside of note start");
`endif

endmodule

`default_nettype wire

/* rtl/core/mns_note_mem.sv */
// ----------------------------------------------------------------------------
// mns_note_mem
// Note table: frequency and duration per entry, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mns_note_mem (
  input  wire logic             clk,
  input  wire mns_pkg::mem_req_t req,
  output mns_pkg::note_t        rdata
);
  import mns_pkg::*;

  note_t mem [MAX_NOTES];
  note_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/mns_tone_div.sv */
// ----------------------------------------------------------------------------
// mns_tone_div
// Restoring divider: tone clock divided by note frequency, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mns_tone_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [15:0]               divisor,
  output logic                           done,
  output logic [mns_pkg::DIV_W-1:0]      quotient
);
  import mns_pkg::*;

  logic                 busy_r,  busy_nxt;
  logic                 done_r,  done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [DIV_W-1:0]     dvd_r,   dvd_nxt;
  logic [DIV_W-1:0]     quo_r,   quo_nxt;
  logic [16:0]          rem_r,   rem_nxt;
  logic [15:0]          dsr_r,   dsr_nxt;
  logic [16:0]          rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    rem_sh   = {rem_r[15:0], dvd_r[DIV_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      dvd_nxt  = DIV_W'(TONE_CLOCK_HZ);
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sh - {1'b0, dsr_r};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the melody note sequencer. Loads note tables, plays
// songs of random notes under several gap settings and checks every status
// beat against an in-bench model of the player, with random stalls both ways.
// ----------------------------------------------------------------------------

module tb_top;
  import mns_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS  = 150;
  localparam int TICK_CAP     = 400;
  localparam int PCT_FULL     = 100;
  localparam int MAX_REPORTS  = 30;
  localparam int LIMIT        = 3_000_000;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  in_t         in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  out_t        out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  melody_note_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---- player model ----
  logic [15:0] pitch_mem [MAX_NOTES];
  logic [15:0] span_mem  [MAX_NOTES];
  logic [15:0] gap_ticks = GAP_RESET;
  logic [9:0]  ms_cnt    = '0;
  logic [15:0] sec_cnt   = '0;
  logic [15:0] phase_cnt = '0;
  logic [6:0]  cur_note  = '0;
  logic [6:0]  song_len  = '0;
  logic        resting   = 1'b0;
  logic [6:0]  vol       = '0;
  logic        tone_run  = 1'b0;
  logic [7:0]  top_val   = '0;
  logic [7:0]  cmp_val   = '0;
  int          audible_starts = 0;

  function automatic void silence();
    tone_run = 1'b0;
    top_val  = '0;
    cmp_val  = '0;
  endfunction

  function automatic void sound_note(input logic [6:0] idx);
    int unsigned quot;
    int unsigned prod;
    logic [15:0] f;
    if (idx >= MAX_NOTES) begin
      silence();
      return;
    end
    f = pitch_mem[idx[5:0]];
    if (f == 0) begin
      silence();
      return;
    end
    quot = TONE_CLOCK_HZ / f;
    // only the low byte of the period survives
    if (quot[7:0] == 0) begin
      silence();
      return;
    end
    tone_run = 1'b1;
    top_val  = quot[7:0] - 8'd1;
    prod     = top_val;
    prod     = prod * vol / PCT_FULL;
    cmp_val  = prod[7:0];
    audible_starts++;
  endfunction

  function automatic void advance_ms();
    ms_cnt = ms_cnt + 10'd1;
    if (ms_cnt >= MS_PER_S) begin
      ms_cnt  = '0;
      sec_cnt = sec_cnt + 16'd1;
    end
    phase_cnt = phase_cnt + 16'd1;
    if (cur_note < song_len && cur_note < MAX_NOTES) begin
      if (!resting && phase_cnt == span_mem[cur_note[5:0]]) begin
        phase_cnt = '0;
        resting   = 1'b1;
        silence();
      end
      // zero gap: next note starts on the same tick
      if (resting && phase_cnt == gap_ticks) begin
        cur_note  = cur_note + 7'd1;
        resting   = 1'b0;
        phase_cnt = '0;
        if (cur_note < song_len) sound_note(cur_note);
        else silence();
      end
    end
  endfunction

  function automatic out_t next_status(input in_t c);
    out_t r;
    case (c.mode)
      MODE_TICK: advance_ms();
      MODE_LOAD: begin
        if (c.note_slot < MAX_NOTES) begin
          pitch_mem[c.note_slot] = c.note_freq;
          span_mem[c.note_slot]  = c.note_duration;
        end
      end
      MODE_PLAY: begin
        song_len  = (c.song_length > MAX_NOTES) ? 7'(MAX_NOTES) : c.song_length;
        cur_note  = '0;
        resting   = 1'b0;
        phase_cnt = '0;
        if (song_len != 0) sound_note(7'd0);
        else silence();
      end
      MODE_VOL_UP:   if (vol < VOL_MAX) vol = vol + 7'(VOL_STEP);
      MODE_VOL_DOWN: if (vol != 0) vol = vol - 7'(VOL_STEP);
      default: ;
    endcase
    r.tone_on       = tone_run;
    r.tone_top      = top_val;
    r.tone_compare  = cmp_val;
    r.seconds       = sec_cnt;
    r.note_position = cur_note;
    r.in_gap        = resting;
    r.volume_level  = vol;
    return r;
  endfunction

  // ---- beat traffic ----
  in_t  cmd_q[$];
  out_t status_q[$];
  int   queued_cnt = 0;
  int   checked    = 0;
  int   err_cnt    = 0;
  int   src_hold   = 0;
  int   src_calm   = 0;
  int   sink_hold  = 0;
  int   sink_calm  = 0;
  bit   quiet      = 1'b0;
  int   cycle_cnt  = 0;

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm || quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : feed
    bit holding;
    holding = in_valid;
    if (src_calm > 0) src_calm--;
    else if (!quiet && $urandom_range(0, 299) == 0) src_calm = $urandom_range(40, 120);
    if (src_hold > 0) src_hold--;
    if (rst_n && in_valid && in_ready) begin
      status_q.push_back(next_status(in_data));
      holding  = 1'b0;
      src_hold = pick_gap(src_calm != 0);
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!holding) begin
      if (src_hold == 0 && cmd_q.size() != 0) begin
        in_data  <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : sink
    out_t want;
    if (sink_calm > 0) sink_calm--;
    else if (!quiet && $urandom_range(0, 299) == 0) sink_calm = $urandom_range(40, 120);
    if (sink_hold > 0) sink_hold--;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t ns: status beat with nothing expected, expected none, got %p",
                   $time, out_data);
      end else begin
        want = status_q.pop_front();
        checked++;
        queued_cnt--;
        check_field("tone_on", want.tone_on, out_data.tone_on);
        check_field("tone_top", want.tone_top, out_data.tone_top);
        check_field("tone_compare", want.tone_compare, out_data.tone_compare);
        check_field("seconds", want.seconds, out_data.seconds);
        check_field("note_position", want.note_position, out_data.note_position);
        check_field("in_gap", want.in_gap, out_data.in_gap);
        check_field("volume_level", want.volume_level, out_data.volume_level);
      end
      sink_hold = pick_gap(sink_calm != 0);
    end else if (sink_hold == 0 && sink_calm == 0 && !quiet && $urandom_range(0, 9) == 0) begin
      sink_hold = $urandom_range(1, 3);
    end
    out_ready <= (sink_hold == 0);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still outstanding", cycle_cnt, queued_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---- stimulus ----
  int items_made = 0;
  int songs      = 0;
  int gap_writes = 0;

  function automatic in_t rand_cmd(input logic [2:0] mode);
    in_t         c;
    logic [63:0] raw;
    raw    = {$urandom, $urandom};
    c      = raw[$bits(in_t)-1:0];
    c.mode = mode;
    return c;
  endfunction

  function automatic logic [15:0] rand_pitch();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'($urandom_range(TONE_CLOCK_HZ + 1, 16'hFFFF));
      2, 3:    return 16'($urandom_range(1, TONE_CLOCK_HZ / 256));
      default: return 16'($urandom_range(TONE_CLOCK_HZ / 256 + 1, TONE_CLOCK_HZ));
    endcase
  endfunction

  task automatic push_cmd(input in_t c);
    cmd_q.push_back(c);
    queued_cnt++;
    items_made++;
  endtask

  task automatic queue_load(input int slot, input logic [15:0] freq, input logic [15:0] dur);
    in_t c;
    c               = rand_cmd(MODE_LOAD);
    c.note_slot     = 6'(slot);
    c.note_freq     = freq;
    c.note_duration = dur;
    push_cmd(c);
  endtask

  task automatic queue_play(input int len);
    in_t c;
    c             = rand_cmd(MODE_PLAY);
    c.song_length = 7'(len);
    push_cmd(c);
    songs++;
  endtask

  // stray beats during a song; never touches the slots being played
  task automatic queue_noise(input int n);
    in_t c;
    case ($urandom_range(0, 5))
      0: c = rand_cmd(MODE_VOL_UP);
      1: c = rand_cmd(MODE_VOL_DOWN);
      2: c = rand_cmd(3'(MODE_VOL_DOWN + $urandom_range(1, 3)));
      3: begin
        c             = rand_cmd(MODE_PLAY);
        c.song_length = 7'($urandom_range(0, n));
      end
      default: begin
        if (n < MAX_NOTES) begin
          c           = rand_cmd(MODE_LOAD);
          c.note_slot = 6'($urandom_range(n, MAX_NOTES - 1));
        end else begin
          c = rand_cmd(MODE_TICK);
        end
      end
    endcase
    push_cmd(c);
  endtask

  task automatic queue_song(input logic [15:0] gap);
    int          n;
    int          budget;
    int          len_field;
    logic [15:0] d;
    case ($urandom_range(0, 9))
      0:       n = MAX_NOTES;
      1, 2:    n = $urandom_range(7, 20);
      default: n = $urandom_range(1, 6);
    endcase
    budget = 4;
    for (int i = 0; i < n; i++) begin
      d = ($urandom_range(0, 3) == 0) ? 16'd1 : 16'($urandom_range(1, 12));
      queue_load(i, rand_pitch(), d);
      budget += d + gap;
    end
    case ($urandom_range(0, 9))
      0: repeat (16) push_cmd(rand_cmd(MODE_VOL_UP));
      1: repeat (16) push_cmd(rand_cmd(MODE_VOL_DOWN));
      default: repeat ($urandom_range(0, 3))
        push_cmd(rand_cmd($urandom_range(0, 2) != 0 ? MODE_VOL_UP : MODE_VOL_DOWN));
    endcase
    // full table lets the length field run past the table size
    if (n == MAX_NOTES && $urandom_range(0, 1) != 0)
      len_field = $urandom_range(MAX_NOTES, (1 << $bits(in_data.song_length)) - 1);
    else
      len_field = n;
    queue_play(len_field);
    if (budget > TICK_CAP) budget = TICK_CAP;
    for (int t = 0; t < budget; t++) begin
      if ($urandom_range(0, 19) == 0) queue_noise(n);
      push_cmd(rand_cmd(MODE_TICK));
    end
  endtask

  task automatic wait_idle();
    while (queued_cnt != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_gap(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    gap_ticks    = v;
    gap_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] gap_plan [0:7];
    logic [15:0] cur_gap;
    in_t         c;
    int          rand_start;
    int          phase_start;
    int          p;

    gap_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd2, GAP_RESET, 16'd7, 16'd0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: volume floor, pitch and slot extremes, unused modes, empty song
    push_cmd(rand_cmd(MODE_VOL_DOWN));
    push_cmd(rand_cmd(MODE_VOL_UP));
    push_cmd(rand_cmd(MODE_VOL_UP));
    queue_load(0, 16'(TONE_CLOCK_HZ / 256), 16'd1);
    queue_load(1, 16'(TONE_CLOCK_HZ / 256 + 1), 16'd2);
    queue_load(2, 16'd1, 16'd1);
    queue_load(3, 16'hFFFF, 16'hFFFF);
    queue_load(MAX_NOTES - 1, 16'd0, 16'd0);
    c = '1;
    push_cmd(c);
    c.mode = MODE_VOL_DOWN + 3'd1;
    push_cmd(c);
    c.mode = MODE_VOL_DOWN + 3'd2;
    push_cmd(c);
    c      = '0;
    c.mode = MODE_PLAY;
    push_cmd(c);
    push_cmd(rand_cmd(MODE_TICK));
    queue_play(3);
    repeat (6) push_cmd(rand_cmd(MODE_TICK));
    c      = '0;
    c.mode = MODE_TICK;
    push_cmd(c);

    // random songs under a series of gap settings
    rand_start = items_made;
    cur_gap    = GAP_RESET;
    p          = 0;
    while (items_made - rand_start < RANDOM_ITEMS) begin
      if (p > 0) begin
        wait_idle();
        cur_gap = (p <= 8) ? gap_plan[p - 1] : 16'($urandom_range(0, 15));
        write_gap(cur_gap);
      end
      phase_start = items_made;
      while (items_made - phase_start < PHASE_ITEMS) queue_song(cur_gap);
      p++;
    end

    // zero-length note keeps sounding well past the usual lengths, zero gap
    wait_idle();
    write_gap(16'd0);
    quiet = 1'b1;
    queue_load(0, 16'd440, 16'd0);
    queue_load(1, 16'(TONE_CLOCK_HZ), 16'd3);
    push_cmd(rand_cmd(MODE_VOL_UP));
    queue_play(2);
    repeat (40) push_cmd(rand_cmd(MODE_TICK));

    wait_idle();
    repeat (40) @(posedge clk);
    $display("sent %0d commands across %0d gap settings, %0d songs, %0d audible note starts",
             items_made, gap_writes + 1, songs, audible_starts);
    $display("checked %0d status beats, %0d mismatches", checked, err_cnt);
    if (err_cnt == 0 && status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
